[hdl/rib_pkg.sv]
`timescale 1ns / 1ps
package rib_pkg;

  localparam int DEF_HEIGHT    = 256;
  localparam int DEF_WIDTH     = 256;
  localparam int DEF_FRAC_BITS = 14;
  // accumulator width of the Lagrange datapath: pixel (8) + fraction + headroom
  localparam int DEF_ACC_W     = DEF_FRAC_BITS + 16;
  localparam int MUL_B_W       = 17;   // second multiplier operand, signed
  localparam int OFS_W         = 14;   // signed row/col offset from the centre

  typedef enum logic [1:0] {
    CFG_SINE   = 2'd0,
    CFG_COSINE = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CO_A,
    ST_CO_B,
    ST_CO_C,
    ST_CO_D,
    ST_CO_E,
    ST_CHECK,
    ST_NRD,
    ST_NWAIT,
    ST_FETCH,
    ST_HINIT,
    ST_HMUL,
    ST_HADD,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

[hdl/rotate_image_bicubic.sv]
`timescale 1ns / 1ps
// Channel   Dir  Word                                             Moves when
// in_       in   tuser: op; tdata: row[7:0] col[15:8] pix[23:16]  in_tvalid & in_tready
// out_      out  tdata: pixel_out[7:0] inside_res[8]              out_tvalid & out_tready
// cfg_      in   cfg_addr index, cfg_wdata value                  cfg_wr_en
//
// Load word: written to image memory in the accept cycle, ready again next cycle.
// Request word: rotation in ST_CO_A..ST_CO_E on the shared multiplier, ST_CHECK, then
//   nearest: ST_NRD, ST_NWAIT; bicubic: 4 rows x (fetch, Horner, divide by 6) plus
//   one column pass of Horner and divide by 6. The single image read port and the
//   one multiplier serialise this work.
// in_tready is high only when the sequencer is idle; a finished word waits in the
//   output register while the next input word is taken.
// Reset (rst_n, synchronous): sine 0, cosine 16384, bicubic mode; image not cleared.
module rotate_image_bicubic
  import rib_pkg::*;
#(
  parameter int HEIGHT    = DEF_HEIGHT,
  parameter int WIDTH     = DEF_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // row[7:0], col[15:8], pixel_in[23:16]
  input  logic        in_tuser,    // op: 0 load, 1 request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // pixel_out[7:0], inside_res[8], zero pad
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int AW     = FRAC_BITS + 16;
  localparam int PW     = AW + MUL_B_W;
  localparam int ND     = (AW + 3) / 4;
  localparam int ZW     = ND * 4;
  localparam int RB     = $clog2(HEIGHT);
  localparam int CB     = $clog2(WIDTH);
  localparam int DEPTH  = HEIGHT * WIDTH;
  localparam int ADDR_W = $clog2(HEIGHT * WIDTH);

  localparam logic signed [PW-1:0] OFF_H = PW'(HEIGHT / 2) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] OFF_W = PW'(WIDTH / 2) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] LIM_H = PW'(HEIGHT) <<< FRAC_BITS;
  localparam logic signed [PW-1:0] LIM_W = PW'(WIDTH) <<< FRAC_BITS;

  // config registers
  logic signed [15:0] sin_r, cos_r;
  logic               mode_r;

  // sequencer
  state_t state_r, state_nxt;
  logic [1:0] i_r;        // neighborhood row in pass 0
  logic [2:0] k_r;        // fetch slot, 0..4
  logic [1:0] step_r;     // Horner step
  logic       pass_r;     // 0 rows over fc, 1 column over fr

  // payload
  logic [7:0]            row_r, col_r;
  logic signed [PW-1:0]  hq_r, wq_r;
  logic [RB-1:0]         r1_r;
  logic [CB-1:0]         c1_r;
  logic [FRAC_BITS-1:0]  fr_r, fc_r;
  logic signed [AW-1:0]  p_r [4];
  logic signed [AW-1:0]  rows_r [4];
  logic signed [AW-1:0]  acc_r;
  logic [7:0]            res_pix_r;
  logic                  res_in_r;
  logic                  out_tvalid_r;
  logic [15:0]           out_tdata_r;

  // datapath wires
  logic signed [AW-1:0]      op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PW-1:0]      prod;
  logic signed [OFS_W-1:0]   dr, dc;
  logic                      in_img;
  logic [RB-1:0]             r1;
  logic [CB-1:0]             c1;
  logic                      near_edge, cub_edge;
  logic signed [AW-1:0]      c3, c2, c1c, c0, coef;
  logic signed [AW-1:0]      horner;
  logic signed [AW-1:0]      half;
  logic [AW:0]               zsum;
  logic [ZW-1:0]             div_z, div_q, qoff;
  logic                      div_start, div_done;
  logic signed [AW-1:0]      lg_res, fin;
  logic [7:0]                fin_pix;
  logic [RB-1:0]             fet_r;
  logic [CB-1:0]             fet_c;
  logic [ADDR_W-1:0]         rd_addr, wr_addr;
  logic [7:0]                rd_data;
  logic                      in_acc, wr_en;

  assign in_acc = in_tvalid && in_tready;

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_r  <= '0;
      cos_r  <= 16'sd16384;
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SINE:   sin_r  <= $signed(cfg_wdata);
        CFG_COSINE: cos_r  <= $signed(cfg_wdata);
        CFG_MODE:   mode_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // ---------------- offsets, bounds, edges ----------------
  assign dr = $signed(OFS_W'(row_r)) - $signed(OFS_W'(HEIGHT / 2));
  assign dc = $signed(OFS_W'(col_r)) - $signed(OFS_W'(WIDTH / 2));

  assign in_img = !hq_r[PW-1] && !wq_r[PW-1] && (hq_r < LIM_H) && (wq_r < LIM_W);
  assign r1     = hq_r[FRAC_BITS +: RB];
  assign c1     = wq_r[FRAC_BITS +: CB];
  assign near_edge = (r1 == RB'(HEIGHT - 1)) || (c1 == CB'(WIDTH - 1));
  assign cub_edge  = (r1 == '0) || (c1 == '0) ||
                     (r1 > RB'(HEIGHT - 3)) || (c1 > CB'(WIDTH - 3));

  // ---------------- Lagrange coefficients (times 6) ----------------
  always_comb begin
    c3  = -p_r[0] + (p_r[1] <<< 1) + p_r[1] - (p_r[2] <<< 1) - p_r[2] + p_r[3];
    c2  = (p_r[0] <<< 1) + p_r[0] - (p_r[1] <<< 2) - (p_r[1] <<< 1) + (p_r[2] <<< 1) + p_r[2];
    c1c = -(p_r[0] <<< 1) - (p_r[1] <<< 1) - p_r[1] + (p_r[2] <<< 2) + (p_r[2] <<< 1) - p_r[3];
    c0  = (p_r[1] <<< 2) + (p_r[1] <<< 1);
    case (step_r)
      2'd0:    coef = c2;
      2'd1:    coef = c1c;
      default: coef = c0;
    endcase
    horner = AW'(prod >>> FRAC_BITS) + coef;
  end

  // floor(acc/6) = floor(floor(acc/2)/3); bias to make the dividend positive
  always_comb begin
    half  = acc_r >>> 1;
    zsum  = (AW + 1)'(half) + ((AW + 1)'(3) << (AW - 2));
    div_z = ZW'(zsum[AW-1:0]);
    qoff  = div_q - (ZW'(1) << (AW - 2));
    lg_res = $signed(qoff[AW-1:0]);
    fin    = lg_res >>> FRAC_BITS;
    if (fin < 0) begin
      fin_pix = 8'd0;
    end else if (fin > AW'(255)) begin
      fin_pix = 8'd255;
    end else begin
      fin_pix = fin[7:0];
    end
  end

  // ---------------- addresses ----------------
  assign fet_r   = r1_r + RB'(i_r) - RB'(1);
  assign fet_c   = c1_r + CB'(k_r[1:0]) - CB'(1);
  assign wr_addr = ADDR_W'(32'(in_tdata[7:0]) * WIDTH + 32'(in_tdata[15:8]));
  assign wr_en   = in_acc && !in_tuser &&
                   (32'(in_tdata[7:0]) < HEIGHT) && (32'(in_tdata[15:8]) < WIDTH);

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc && in_tuser) state_nxt = ST_CO_A;
      ST_CO_A:   state_nxt = ST_CO_B;
      ST_CO_B:   state_nxt = ST_CO_C;
      ST_CO_C:   state_nxt = ST_CO_D;
      ST_CO_D:   state_nxt = ST_CO_E;
      ST_CO_E:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!in_img) state_nxt = ST_EMIT;
        else if (!mode_r) state_nxt = near_edge ? ST_EMIT : ST_NRD;
        else state_nxt = cub_edge ? ST_EMIT : ST_FETCH;
      end
      ST_NRD:    state_nxt = ST_NWAIT;
      ST_NWAIT:  state_nxt = ST_EMIT;
      ST_FETCH:  if (k_r == 3'd4) state_nxt = ST_HINIT;
      ST_HINIT:  state_nxt = ST_HMUL;
      ST_HMUL:   state_nxt = ST_HADD;
      ST_HADD:   state_nxt = (step_r == 2'd2) ? ST_DSTART : ST_HMUL;
      ST_DSTART: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (pass_r) state_nxt = ST_EMIT;
          else state_nxt = (i_r == 2'd3) ? ST_HINIT : ST_FETCH;
        end
      end
      ST_EMIT:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs ----------------
  always_comb begin
    op_a      = '0;
    op_b      = '0;
    rd_addr   = ADDR_W'(32'(fet_r) * WIDTH + 32'(fet_c));
    div_start = (state_r == ST_DSTART);
    in_tready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_CO_A: begin op_a = AW'(sin_r); op_b = MUL_B_W'(dc); end
      ST_CO_B: begin op_a = AW'(cos_r); op_b = MUL_B_W'(dr); end
      ST_CO_C: begin op_a = AW'(cos_r); op_b = MUL_B_W'(dc); end
      ST_CO_D: begin op_a = AW'(sin_r); op_b = MUL_B_W'(dr); end
      ST_HMUL: begin
        op_a = acc_r;
        op_b = $signed(MUL_B_W'(pass_r ? fr_r : fc_r));
      end
      ST_NRD:  rd_addr = ADDR_W'(32'(r1_r) * WIDTH + 32'(c1_r));
      default: ;
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      k_r          <= '0;
      step_r       <= '0;
      pass_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // emit refills the output register in the cycle the old word leaves
      if (state_r == ST_EMIT && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CHECK: begin
          i_r    <= '0;
          k_r    <= '0;
          pass_r <= 1'b0;
        end
        ST_FETCH: k_r <= k_r + 3'd1;
        ST_HINIT: step_r <= '0;
        ST_HADD:  step_r <= step_r + 2'd1;
        ST_DIV: begin
          if (div_done && !pass_r) begin
            if (i_r == 2'd3) pass_r <= 1'b1;
            i_r <= i_r + 2'd1;
            k_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        row_r <= in_tdata[7:0];
        col_r <= in_tdata[15:8];
      end
      ST_CO_B: hq_r <= prod;
      ST_CO_C: hq_r <= hq_r + prod + OFF_H;
      ST_CO_D: wq_r <= prod;
      ST_CO_E: wq_r <= wq_r - prod + OFF_W;
      ST_CHECK: begin
        r1_r      <= r1;
        c1_r      <= c1;
        fr_r      <= hq_r[FRAC_BITS-1:0];
        fc_r      <= wq_r[FRAC_BITS-1:0];
        res_in_r  <= in_img;
        res_pix_r <= 8'd0;
      end
      ST_NWAIT: res_pix_r <= rd_data;
      ST_FETCH: begin
        if (k_r != 3'd0) p_r[2'(k_r - 3'd1)] <= AW'(rd_data) <<< FRAC_BITS;
      end
      ST_HINIT: acc_r <= c3;
      ST_HADD:  acc_r <= horner;
      ST_DIV: begin
        if (div_done) begin
          if (pass_r) begin
            res_pix_r <= fin_pix;
          end else begin
            rows_r[i_r] <= lg_res;
            if (i_r == 2'd3) begin
              p_r[0] <= rows_r[0];
              p_r[1] <= rows_r[1];
              p_r[2] <= rows_r[2];
              p_r[3] <= lg_res;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) out_tdata_r <= {7'd0, res_in_r, res_pix_r};
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- units ----------------
  rib_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata[23:16]),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rib_mul #(.A_W(AW)) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  rib_div3 #(.A_W(AW)) u_div3 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_z),
    .done     (div_done),
    .quot     (div_q)
  );

  // ---------------- assertions ----------------
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result word raised outside emit");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tdata_r[8] |-> out_tdata_r[7:0] == 8'd0)
    else $error("outside result carries a pixel");

  a_fetch_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FETCH |-> k_r <= 3'd4)
    else $error("fetch slot overrun");

  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tuser |=> state_r == ST_IDLE)
    else $error("load word started the sequencer");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divide finished while not awaited");

endmodule

[hdl/rib_mem.sv]
`timescale 1ns / 1ps
module rib_mem
  import rib_pkg::*;
#(
  parameter int DEPTH  = DEF_HEIGHT * DEF_WIDTH,
  parameter int ADDR_W = $clog2(DEF_HEIGHT * DEF_WIDTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/rib_mul.sv]
`timescale 1ns / 1ps
module rib_mul
  import rib_pkg::*;
#(
  parameter int A_W = DEF_ACC_W
) (
  input  logic                        clk,
  input  logic signed [A_W-1:0]       op_a,
  input  logic signed [MUL_B_W-1:0]   op_b,
  output logic signed [A_W+MUL_B_W-1:0] prod
);

  logic signed [A_W+MUL_B_W-1:0] prod_r;

  // one registered signed product per cycle
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

[hdl/rib_div3.sv]
`timescale 1ns / 1ps
module rib_div3
  import rib_pkg::*;
#(
  parameter int A_W = DEF_ACC_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [((A_W+3)/4)*4-1:0]    dividend,
  output logic                        done,
  output logic [((A_W+3)/4)*4-1:0]    quot
);

  localparam int ND   = (A_W + 3) / 4;
  localparam int ZW   = ND * 4;
  localparam int CNTW = $clog2(ND + 1);

  logic [ZW-1:0]   z_r;
  logic [ZW-1:0]   q_r;
  logic [1:0]      rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [5:0]  t;
  logic [14:0] m;
  logic [3:0]  qd;
  logic [1:0]  rem_nxt;

  // one nibble per cycle; t < 48 so t/3 = (t*171) >> 9 exactly
  always_comb begin
    t       = {rem_r, z_r[ZW-1 -: 4]};
    m       = 15'(t) * 15'd171;
    qd      = m[12:9];
    rem_nxt = 2'(t - 6'(qd) * 6'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(ND);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z_r   <= dividend;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      z_r   <= z_r << 4;
      q_r   <= {q_r[ZW-5:0], qd};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[verif/tb_rotate_image_bicubic.sv]
`timescale 1ns / 1ps
// Checks the rotated-image sampler against its own predictor. Pixels are loaded on
// demand: before a request goes out, every pixel it will read that was never
// loaded is loaded first, so no request reads an unwritten pixel.
// Each random phase follows a setting of sine, cosine and mode and sends a mix of loads and requests.
module tb_rotate_image_bicubic;
  import rib_pkg::*;

  localparam int         HT          = 256;
  localparam int         WD          = 256;
  localparam int         FB          = 14;
  localparam logic       OP_LOAD     = 1'b0;
  localparam logic       OP_REQ      = 1'b1;
  localparam logic       MODE_NEAR   = 1'b0;
  localparam logic       MODE_CUBIC  = 1'b1;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;  // index with no register behind it
  localparam int         STALL_LIMIT = 6000;  // cycles without any handshake
  localparam int         HOLD_CYC    = 500;   // long receiver hold-off

  // ---------------------------------------------------------------------------
  // Scoreboard: mirror of the image and the registers, queue of expected pixels
  // ---------------------------------------------------------------------------
  class rot_scoreboard;
    bit [7:0]    img[HT*WD];
    bit          written[HT*WD];   // set by the sender when it issues a load
    longint      sin_q, cos_q;
    bit          mode;
    bit [8:0]    pending[$];   // {inside, pixel}
    int          errors, n_loads, n_reqs, n_results, n_outside, n_inside;

    function new();
      sin_q = 0; cos_q = 16384; mode = MODE_CUBIC;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SINE:   sin_q = longint'($signed(val));
        CFG_COSINE: cos_q = longint'($signed(val));
        CFG_MODE:   mode  = val[0];
        default: ;
      endcase
    endfunction

    function longint div6_floor(longint x);
      longint q;
      q = x / 6;
      if (x % 6 != 0 && x < 0) q = q - 1;
      return q;
    endfunction

    // cubic through p0..p3 at fraction f, Horner with floored rescaling
    function longint cubic_at(longint p0, longint p1, longint p2, longint p3, longint f);
      longint acc;
      acc = -p0 + 3*p1 - 3*p2 + p3;
      acc = ((acc * f) >>> FB) + (3*p0 - 6*p1 + 3*p2);
      acc = ((acc * f) >>> FB) + (-2*p0 - 3*p1 + 6*p2 - p3);
      acc = ((acc * f) >>> FB) + 6*p1;
      return div6_floor(acc);
    endfunction

    function longint px(longint r, longint c);
      return longint'(img[r*WD + c]) <<< FB;
    endfunction

    // image addresses a request reads under the current registers
    function void reads_of(bit [7:0] row, bit [7:0] col, ref int lst[$]);
      longint hq, wq, r1, c1;
      lst.delete();
      hq = sin_q*(longint'(col) - WD/2) + cos_q*(longint'(row) - HT/2) + ((HT/2) <<< FB);
      wq = cos_q*(longint'(col) - WD/2) - sin_q*(longint'(row) - HT/2) + ((WD/2) <<< FB);
      if (hq < 0 || wq < 0 || hq >= (longint'(HT) <<< FB) || wq >= (longint'(WD) <<< FB))
        return;
      r1 = hq >>> FB; c1 = wq >>> FB;
      if (mode == MODE_NEAR) begin
        if (r1 != HT-1 && c1 != WD-1) lst.push_back(int'(r1*WD + c1));
      end else if (r1 != 0 && c1 != 0 && r1 <= HT-3 && c1 <= WD-3) begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 4; j++)
            lst.push_back(int'((r1-1+i)*WD + c1-1+j));
      end
    endfunction

    function int n_missing(bit [7:0] row, bit [7:0] col);
      int lst[$];
      int n;
      n = 0;
      reads_of(row, col, lst);
      foreach (lst[j]) if (!written[lst[j]]) n++;
      return n;
    endfunction

    function void note_word(bit op, bit [7:0] row, bit [7:0] col, bit [7:0] pin);
      longint hq, wq, r1, c1, fr, fc, val;
      longint rv[4];
      if (op == OP_LOAD) begin
        img[int'(row)*WD + int'(col)] = pin;
        n_loads++;
        return;
      end
      n_reqs++;
      hq = sin_q*(longint'(col) - WD/2) + cos_q*(longint'(row) - HT/2) + ((HT/2) <<< FB);
      wq = cos_q*(longint'(col) - WD/2) - sin_q*(longint'(row) - HT/2) + ((WD/2) <<< FB);
      if (hq < 0 || wq < 0 || hq >= (longint'(HT) <<< FB) || wq >= (longint'(WD) <<< FB)) begin
        pending.push_back(9'd0);
        n_outside++;
        return;
      end
      n_inside++;
      r1 = hq >>> FB; c1 = wq >>> FB;
      fr = hq & ((1 <<< FB) - 1); fc = wq & ((1 <<< FB) - 1);
      val = 0;
      if (mode == MODE_NEAR) begin
        if (r1 != HT-1 && c1 != WD-1) val = img[r1*WD + c1];
      end else if (r1 != 0 && c1 != 0 && r1 <= HT-3 && c1 <= WD-3) begin
        for (int i = 0; i < 4; i++)
          rv[i] = cubic_at(px(r1-1+i, c1-1), px(r1-1+i, c1), px(r1-1+i, c1+1),
                           px(r1-1+i, c1+2), fc);
        val = cubic_at(rv[0], rv[1], rv[2], rv[3], fr) >>> FB;
        if (val < 0) val = 0;
        if (val > 255) val = 255;
      end
      pending.push_back({1'b1, val[7:0]});
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_word(logic [15:0] d);
      bit [8:0] exp_w;
      n_results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result word %h", d));
        return;
      end
      exp_w = pending.pop_front();
      if (d[7:0] !== exp_w[7:0])
        report($sformatf("pixel_out %0d, predicted %0d", d[7:0], exp_w[7:0]));
      if (d[8] !== exp_w[8])
        report($sformatf("inside_res %b, predicted %b", d[8], exp_w[8]));
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [15:0] out_tdata;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  rot_scoreboard sb;
  bit quiet;       // no idling on either side
  bit hold_req;    // receiver: hold off for a long stretch
  int stall_cnt;

  rotate_image_bicubic dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitors: sample handshakes with pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_word(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(out_tdata);
  end

  // Watchdog: any handshake resets the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random back-pressure, with one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 18);
      end
    end
  end

  // Pixel values lean on the extremes so bicubic overshoot hits both clamps
  function automatic bit [7:0] pick_pix();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // One word on the input stream; valid stays high between back-to-back words
  task send_word(bit op, bit [7:0] row, bit [7:0] col, bit [7:0] pin, bit may_idle);
    while (may_idle && !quiet && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {pin, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task load(int r, int c, bit [7:0] v);
    sb.written[r*WD + c] = 1'b1;
    send_word(OP_LOAD, r[7:0], c[7:0], v, 1'b1);
  endtask

  task end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender waits until every predicted pixel has come back, plus load latency
  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task set_angle(int s, int c, bit m);
    write_reg(CFG_SINE, s[15:0]);
    write_reg(CFG_COSINE, c[15:0]);
    write_reg(CFG_MODE, {15'd0, m});
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Request; pixels it reads that were never loaded go out first
  task req(int r, int c);
    int lst[$];
    sb.reads_of(r[7:0], c[7:0], lst);
    foreach (lst[j])
      if (!sb.written[lst[j]]) load(lst[j] / WD, lst[j] % WD, pick_pix());
    send_word(OP_REQ, r[7:0], c[7:0], 8'($urandom), 1'b1);
  endtask

  // Random phase: requests anywhere when they read only loaded pixels, otherwise
  // near the center; some loads repaint pixels around the center
  task rand_phase(int n, bit with_hold);
    int r, c;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n/3) hold_req = 1'b1;
      if ($urandom_range(3) == 0) begin
        load(116 + $urandom_range(24), 116 + $urandom_range(24), pick_pix());
      end else begin
        r = $urandom_range(255);
        c = $urandom_range(255);
        if (sb.n_missing(r[7:0], c[7:0]) != 0) begin
          r = 123 + $urandom_range(10);
          c = 123 + $urandom_range(10);
        end
        req(r, c);
      end
    end
    end_burst();
    drain();
  endtask

  initial begin
    int s, c;
    sb = new();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    quiet = 1'b0; hold_req = 1'b0; stall_cnt = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity rotation, bicubic (reset values)
    req(128, 128); req(0, 0); req(255, 255); req(0, 255); req(255, 0);
    req(1, 1); req(253, 253); req(254, 100); req(100, 254);
    end_burst();
    drain();
    // Nearest: last row/column give zero
    set_angle(0, 16384, MODE_NEAR);
    req(255, 10); req(10, 255); req(254, 254); req(0, 0); req(77, 200);
    end_burst();
    drain();
    // Unknown index must change nothing
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    req(40, 41);
    end_burst();
    drain();
    // Extreme registers: 45 deg scaled up; far corners fall outside
    set_angle(16384, 16384, MODE_CUBIC);
    req(0, 0); req(255, 255); req(128, 128); req(100, 130); req(0, 128);
    end_burst();
    drain();
    set_angle(-16384, -16384, MODE_NEAR);
    req(255, 0); req(128, 128); req(130, 120);
    end_burst();
    drain();

    // Random phases over several settings, extremes among them
    set_angle(16384, 0, MODE_CUBIC);      rand_phase(80, 1'b0);
    set_angle(-16384, 0, MODE_NEAR);      rand_phase(80, 1'b1);
    quiet = 1'b1;
    set_angle(0, -16384, MODE_CUBIC);     rand_phase(80, 1'b0);
    quiet = 1'b0;
    set_angle(11585, 11585, MODE_CUBIC);  rand_phase(80, 1'b0);
    set_angle(16384, 16384, MODE_NEAR);   rand_phase(70, 1'b0);
    set_angle(0, 16384, MODE_CUBIC);      rand_phase(80, 1'b0);
    for (int p = 0; p < 3; p++) begin
      s = $urandom_range(32768) - 16384;
      c = $urandom_range(32768) - 16384;
      set_angle(s, c, 1'($urandom));
      rand_phase(75, p == 1);
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d loads and %0d requests (%0d inside, %0d outside), %0d results",
             sb.n_loads, sb.n_reqs, sb.n_inside, sb.n_outside, sb.n_results);
    $display("Settings: identity, quarter turns, half turn, 45 deg, random angles; both modes");
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d predicted pixels never arrived", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
